// ----- rtl/uuidp_pkg.sv -----
// ----------------------------------------------------------------------------
// UUID text parser package
// Shared types, character codes and the hex digit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package uuidp_pkg;

    localparam int unsigned CH_W    = 8;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned BYTES_W = 5;
    localparam int unsigned HALF_W  = 64;

    localparam logic [CH_W-1:0] CH_HYPHEN = 8'h2D;
    localparam logic [CH_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CH_W-1:0] CH_RBRACE = 8'h7D;

    localparam logic [CNT_W-1:0] COUNT_MAX  = 6'd63;
    localparam logic [CNT_W-1:0] LEN_PLAIN  = 6'd32;
    localparam logic [CNT_W-1:0] LEN_HYPHEN = 6'd36;
    localparam logic [CNT_W-1:0] LEN_BRACED = 6'd38;

    localparam logic [BYTES_W-1:0] UUID_BYTES = 5'd16;
    localparam logic [BYTES_W-1:0] HIGH_BYTES = 5'd8;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } t_char_item;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_hex;

    function automatic t_hex hex_decode(input logic [CH_W-1:0] c);
        t_hex res;
        res.ok  = 1'b0;
        res.nib = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            res.ok  = 1'b1;
            res.nib = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            res.ok  = 1'b1;
            res.nib = 4'(c[3:0] + 4'd9);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/uuidp_if.sv -----
// ----------------------------------------------------------------------------
// UUID text parser channels
// Character input channel and UUID result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface uuidp_char_if;
    logic                        valid;
    logic                        ready;
    logic [uuidp_pkg::CH_W-1:0]  ch;
    logic                        last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface uuidp_res_if;
    logic                          valid;
    logic                          ready;
    logic [uuidp_pkg::HALF_W-1:0]  uuid_high;
    logic [uuidp_pkg::HALF_W-1:0]  uuid_low;
    logic                          parse_failed;

    modport source (output valid, output uuid_high, output uuid_low,
                    output parse_failed, input ready);
    modport sink   (input valid, input uuid_high, input uuid_low,
                    input parse_failed, output ready);
endinterface

`default_nettype wire

// ----- rtl/uuidp_in_reg.sv -----
// ----------------------------------------------------------------------------
// UUID text parser input register
// Holds one character item until the parser core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module uuidp_in_reg (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    input  uuidp_pkg::t_char_item  i_item,
    output logic                   o_ready,
    input  wire                    i_take,
    output logic                   o_valid,
    output uuidp_pkg::t_char_item  o_item
);

    logic                  r_valid;
    uuidp_pkg::t_char_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/uuidp_core.sv -----
// ----------------------------------------------------------------------------
// UUID text parser core
// Per-character state update, byte assembly and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module uuidp_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    input  uuidp_pkg::t_char_item            i_item,
    output logic                             o_take,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic [uuidp_pkg::HALF_W-1:0]     o_uuid_high,
    output logic [uuidp_pkg::HALF_W-1:0]     o_uuid_low,
    output logic                             o_parse_failed
);

    logic [uuidp_pkg::CNT_W-1:0]   r_char_count, n_char_count;
    logic [uuidp_pkg::BYTES_W-1:0] r_byte_count, n_byte_count;
    logic [3:0]                    r_pending_high, n_pending_high;
    logic                          r_half_pair, n_half_pair;
    logic                          r_brace_open, n_brace_open;
    logic                          r_failed, n_failed;
    logic [uuidp_pkg::HALF_W-1:0]  r_asm_high, n_asm_high;
    logic [uuidp_pkg::HALF_W-1:0]  r_asm_low, n_asm_low;

    logic                          r_out_valid;
    logic [uuidp_pkg::HALF_W-1:0]  r_out_high, n_out_high;
    logic [uuidp_pkg::HALF_W-1:0]  r_out_low, n_out_low;
    logic                          r_out_failed, n_out_failed;

    logic [uuidp_pkg::CNT_W-1:0]   cnt;
    logic                          brace_start;
    logic                          brace;
    logic                          process;
    logic                          len_ok;
    logic                          res_ok;
    logic [7:0]                    new_byte;
    uuidp_pkg::t_hex               hex;

    assign o_take = i_valid && (!i_item.last || !r_out_valid || i_ready);

    always_comb begin
        hex         = uuidp_pkg::hex_decode(i_item.ch);
        cnt         = (r_char_count != uuidp_pkg::COUNT_MAX) ?
                      6'(r_char_count + 6'd1) : uuidp_pkg::COUNT_MAX;
        brace_start = (r_char_count == '0) && (i_item.ch == uuidp_pkg::CH_LBRACE);
        brace       = r_brace_open || brace_start;
        process     = !brace_start && !(brace && i_item.last) && !r_failed;
        new_byte    = {r_pending_high, hex.nib};

        n_char_count   = r_char_count;
        n_byte_count   = r_byte_count;
        n_pending_high = r_pending_high;
        n_half_pair    = r_half_pair;
        n_brace_open   = r_brace_open;
        n_failed       = r_failed;
        n_asm_high     = r_asm_high;
        n_asm_low      = r_asm_low;

        if (process) begin
            if (!r_half_pair) begin
                if (i_item.ch != uuidp_pkg::CH_HYPHEN) begin
                    if (r_byte_count >= uuidp_pkg::UUID_BYTES || !hex.ok) begin
                        n_failed = 1'b1;
                    end else begin
                        n_pending_high = hex.nib;
                        n_half_pair    = 1'b1;
                    end
                end
            end else begin
                if (!hex.ok) begin
                    n_failed = 1'b1;
                end else begin
                    if (r_byte_count < uuidp_pkg::HIGH_BYTES) begin
                        n_asm_high = {r_asm_high[uuidp_pkg::HALF_W-9:0], new_byte};
                    end else begin
                        n_asm_low = {r_asm_low[uuidp_pkg::HALF_W-9:0], new_byte};
                    end
                    n_byte_count   = 5'(r_byte_count + 5'd1);
                    n_half_pair    = 1'b0;
                    n_pending_high = 4'd0;
                end
            end
        end

        len_ok = brace ? (cnt == uuidp_pkg::LEN_BRACED && i_item.ch == uuidp_pkg::CH_RBRACE)
                       : (cnt == uuidp_pkg::LEN_PLAIN || cnt == uuidp_pkg::LEN_HYPHEN);
        res_ok = !n_failed && !n_half_pair && (n_byte_count == uuidp_pkg::UUID_BYTES)
                 && len_ok;

        n_out_high   = res_ok ? n_asm_high : '0;
        n_out_low    = res_ok ? n_asm_low : '0;
        n_out_failed = !res_ok;

        if (i_item.last) begin
            n_char_count   = '0;
            n_byte_count   = '0;
            n_pending_high = '0;
            n_half_pair    = 1'b0;
            n_brace_open   = 1'b0;
            n_failed       = 1'b0;
            n_asm_high     = '0;
            n_asm_low      = '0;
        end else begin
            n_char_count = cnt;
            n_brace_open = brace;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count   <= '0;
            r_byte_count   <= '0;
            r_pending_high <= '0;
            r_half_pair    <= 1'b0;
            r_brace_open   <= 1'b0;
            r_failed       <= 1'b0;
            r_asm_high     <= '0;
            r_asm_low      <= '0;
        end else if (o_take) begin
            r_char_count   <= n_char_count;
            r_byte_count   <= n_byte_count;
            r_pending_high <= n_pending_high;
            r_half_pair    <= n_half_pair;
            r_brace_open   <= n_brace_open;
            r_failed       <= n_failed;
            r_asm_high     <= n_asm_high;
            r_asm_low      <= n_asm_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && i_item.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_item.last) begin
            r_out_high   <= n_out_high;
            r_out_low    <= n_out_low;
            r_out_failed <= n_out_failed;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_uuid_high    = r_out_high;
    assign o_uuid_low     = r_out_low;
    assign o_parse_failed = r_out_failed;

endmodule

`default_nettype wire

// ----- rtl/uuid_text_parser_top.sv -----
// ----------------------------------------------------------------------------
// UUID text parser
// Parses a UUID written as text into 128 bits with a failure flag.
//
// The character channel carries one character per item, with last set on
// the final character of a string. The result channel gives exactly one item
// per string: the two 64-bit halves and parse_failed. A rejected string gives
// all-zero halves with parse_failed set.
// A character is taken into an input register; from there the parser state
// is updated and, on the final character, the result register is loaded,
// which makes the result valid. One character is accepted every cycle while
// no final character is held back in the input register.
// When the receiver stalls, the result waits in its register; characters
// that are not final still advance, and a final character waits in the
// input register until the result register is free, which then holds off
// the character channel. A synchronous reset empties both registers and
// clears the parser state.
// ----------------------------------------------------------------------------
`default_nettype none

module uuid_text_parser_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    uuidp_char_if.sink   i_char,
    uuidp_res_if.source  o_res
);

    uuidp_pkg::t_char_item in_item;
    uuidp_pkg::t_char_item core_item;
    logic                  core_valid;
    logic                  core_take;
    logic                  in_ready;

    assign in_item.ch   = i_char.ch;
    assign in_item.last = i_char.last;
    assign i_char.ready = in_ready;

    uuidp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_char.valid),
        .i_item  (in_item),
        .o_ready (in_ready),
        .i_take  (core_take),
        .o_valid (core_valid),
        .o_item  (core_item)
    );

    uuidp_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (core_valid),
        .i_item         (core_item),
        .o_take         (core_take),
        .o_valid        (o_res.valid),
        .i_ready        (o_res.ready),
        .o_uuid_high    (o_res.uuid_high),
        .o_uuid_low     (o_res.uuid_low),
        .o_parse_failed (o_res.parse_failed)
    );

endmodule

`default_nettype wire
